### hdl/b2da_pkg.sv
package b2da_pkg;

    localparam int MAX_DIGITS_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int VALUE_W     = 32;
    localparam int MAG_W       = VALUE_W - 1;
    localparam int CHAR_W      = 6;
    localparam int DIGIT_W     = 4;
    localparam int RECIP_W     = 32;
    localparam int RECIP_SHIFT = 35;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam int QUO_W       = PROD_W - RECIP_SHIFT;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
    localparam logic [RECIP_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;

    typedef enum logic [1:0] {
        KIND_POS,
        KIND_ZERO,
        KIND_NEG
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [MAG_W-1:0] mag;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

### hdl/b2da_front.sv
module b2da_front
    import b2da_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [VALUE_W-1:0] value,
    input  qstat_t             q_stat,
    output logic               q_push,
    output item_t              q_item
);

    logic  front_valid_reg;
    logic  front_valid_next;
    item_t front_item_reg;
    item_t front_item_next;
    logic  load;

    assign q_push = front_valid_reg && !q_stat.full;
    assign full   = front_valid_reg && q_stat.full;
    assign load   = push && !full;
    assign q_item = front_item_reg;

    // sign and zero classification
    always_comb
    begin
        front_item_next.mag = value[MAG_W-1:0];
        if (value[VALUE_W-1])
        begin
            front_item_next.kind = KIND_NEG;
        end
        else if (value == '0)
        begin
            front_item_next.kind = KIND_ZERO;
        end
        else
        begin
            front_item_next.kind = KIND_POS;
        end
    end

    assign front_valid_next = load || (front_valid_reg && !q_push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            front_item_reg <= front_item_next;
        end
    end

endmodule

### hdl/b2da_queue.sv
module b2da_queue
    import b2da_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  item_t  wr_item,
    input  logic   rd_en,
    output item_t  rd_item,
    output qstat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    item_t            slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign stat.full  = (count_reg == DEPTH_CNT);
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_item    = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

### hdl/b2da_back.sv
module b2da_back
    import b2da_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  qstat_t            q_stat,
    input  item_t             q_item,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output logic [CHAR_W-1:0] digit_char,
    output logic              empty_res,
    output logic              last
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam logic [CNT_W-1:0] LAST_N = CNT_W'(MAX_DIGITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t             state_reg;
    logic [MAG_W-1:0]   x_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DIGIT_W-1:0] digits_reg [MAX_DIGITS];
    logic [CNT_W-1:0]   n_reg;
    logic               neg_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               empty_res_reg;
    logic               last_reg;

    logic [QUO_W-1:0]   quo;
    logic [MAG_W:0]     ten_quo;
    logic [MAG_W:0]     rem;
    logic [CNT_W-1:0]   n_m1;
    logic [DIGIT_W-1:0] emit_digit;
    logic               can_load;

    assign quo        = prod_reg[PROD_W-1:RECIP_SHIFT];
    assign ten_quo    = (MAG_W+1)'({quo, 3'b000}) + (MAG_W+1)'({quo, 1'b0});
    assign rem        = (MAG_W+1)'(x_reg) - ten_quo;
    assign n_m1       = n_reg - 1'b1;
    assign emit_digit = digits_reg[n_m1[IDX_W-1:0]];
    assign can_load   = !out_valid_reg || pop;

    assign q_pop      = (state_reg == ST_IDLE) && !q_stat.empty;
    assign empty      = !out_valid_reg;
    assign digit_char = char_reg;
    assign empty_res  = empty_res_reg;
    assign last       = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            prod_reg      <= '0;
            n_reg         <= '0;
            neg_reg       <= 1'b0;
            char_reg      <= '0;
            empty_res_reg <= 1'b0;
            last_reg      <= 1'b0;
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                digits_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == ST_EMIT && can_load)
            begin
                out_valid_reg <= 1'b1;
                empty_res_reg <= neg_reg;
                last_reg      <= (n_reg == CNT_W'(1));
                char_reg      <= neg_reg ? '0 : ASCII_ZERO + CHAR_W'(emit_digit);
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        x_reg   <= q_item.mag;
                        n_reg   <= '0;
                        neg_reg <= 1'b0;
                        case (q_item.kind)
                            KIND_NEG:
                            begin
                                neg_reg   <= 1'b1;
                                n_reg     <= CNT_W'(1);
                                state_reg <= ST_EMIT;
                            end
                            KIND_ZERO:
                            begin
                                digits_reg[0] <= '0;
                                n_reg         <= CNT_W'(1);
                                state_reg     <= ST_EMIT;
                            end
                            default:
                            begin
                                state_reg <= ST_MUL;
                            end
                        endcase
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= PROD_W'(x_reg) * PROD_W'(RECIP_TEN);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    // one digit per cycle, next reciprocal product runs alongside
                    digits_reg[n_reg[IDX_W-1:0]] <= rem[DIGIT_W-1:0];
                    x_reg    <= MAG_W'(quo);
                    prod_reg <= PROD_W'(quo) * PROD_W'(RECIP_TEN);
                    n_reg    <= n_reg + 1'b1;
                    if (quo == '0 || n_reg == LAST_N)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (can_load)
                    begin
                        n_reg <= n_m1;
                        if (n_reg == CNT_W'(1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/binary_to_decimal_ascii.sv
// Signed 32-bit to decimal ASCII converter. Each request pushed in gives a run of results,
// most significant digit first, with last set on the final one; zero gives a single '0' and
// a negative value gives one result with empty_res set and digit_char 0. Only the lowest
// MAX_DIGITS digits are kept, so wide values may start with '0'. A positive value is handled in
// steps: a dequeue, priming of the reciprocal multiplier, a divide-by-ten loop (one digit per
// cycle through the multiply and remainder loop) and a drain of the digits through the single
// output register, which waits on pop. Zero and negative values go from the dequeue straight to
// the output stage. A small queue between the input stage and the converter lets new requests
// be taken while a run is still being produced.
module binary_to_decimal_ascii
    import b2da_pkg::*;
#(
    parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [VALUE_W-1:0] value,
    output logic               empty,
    input  logic               pop,
    output logic [CHAR_W-1:0]  digit_char,
    output logic               empty_res,
    output logic               last
);

    qstat_t q_stat;
    logic   q_push;
    item_t  q_wr_item;
    logic   q_pop;
    item_t  q_rd_item;

    b2da_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .value  (value),
        .q_stat (q_stat),
        .q_push (q_push),
        .q_item (q_wr_item)
    );

    b2da_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (q_wr_item),
        .rd_en   (q_pop),
        .rd_item (q_rd_item),
        .stat    (q_stat)
    );

    b2da_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .q_item     (q_rd_item),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .digit_char (digit_char),
        .empty_res  (empty_res),
        .last       (last)
    );

endmodule

### hdl/b2da_checker.sv
module b2da_checker
    import b2da_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic [VALUE_W-1:0] value,
    input logic               empty,
    input logic               pop,
    input logic [CHAR_W-1:0]  digit_char,
    input logic               empty_res,
    input logic               last
);

    logic unused_in;
    assign unused_in = push ^ full ^ (^value);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(digit_char) && $stable(empty_res) && $stable(last))
        else $error("stalled result changed");

    // negative run is a single flagged result
    a_neg: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && empty_res |-> digit_char == '0 && last)
        else $error("empty result malformed");

    // digits are ascii 0..9
    a_digit: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !empty_res |-> digit_char >= ASCII_ZERO && digit_char <= ASCII_ZERO + 6'd9)
        else $error("digit out of range");

    // a flagged result never sits inside a digit run
    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !last ##1 !empty |-> !empty_res)
        else $error("empty flag inside digit run");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);

### sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import b2da_pkg::*;

    localparam int N_DIGITS       = MAX_DIGITS_DEF;
    localparam int IDLE_PCT       = 18;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 60;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              blank;
        logic              fin;
    } dec_char_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [VALUE_W-1:0] value = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [CHAR_W-1:0]  digit_char;
    logic               empty_res;
    logic               last;

    logic [VALUE_W-1:0] values_to_send[$];
    dec_char_t          chars_due[$];
    int                 errors = 0;
    logic               calm = 1'b0;
    logic               hold_go = 1'b0;
    logic               hold_done = 1'b0;
    int                 hold_left = 0;
    int                 quiet_cycles = 0;

    binary_to_decimal_ascii i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .value      (value),
        .empty      (empty),
        .pop        (pop),
        .digit_char (digit_char),
        .empty_res  (empty_res),
        .last       (last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // decimal text of one request, most significant digit first
    function automatic void convert_value(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] rest;
        logic [DIGIT_W-1:0] low_first[N_DIGITS];
        int                 n;
        rest = v;
        n = 0;
        if (v[VALUE_W-1])
        begin
            chars_due.push_back('{ch: '0, blank: 1'b1, fin: 1'b1});
        end
        else if (v == '0)
        begin
            chars_due.push_back('{ch: ASCII_ZERO, blank: 1'b0, fin: 1'b1});
        end
        else
        begin
            while (rest != '0 && n < N_DIGITS)
            begin
                low_first[n] = DIGIT_W'(rest % 10);
                rest = rest / 10;
                n++;
            end
            for (int k = n - 1; k >= 0; k--)
            begin
                chars_due.push_back('{ch: ASCII_ZERO + CHAR_W'(low_first[k]), blank: 1'b0,
                                      fin: (k == 0)});
            end
        end
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        int     pick;
        int     width;
        longint lo;
        longint hi;
        pick = $urandom_range(9);
        case (pick)
            0: return '0;
            1: return {1'b1, 31'($urandom)};
            2, 3: return $urandom;
            default:
            begin
                width = $urandom_range(1, 10);
                lo = 1;
                repeat (width - 1) lo = lo * 10;
                hi = lo * 10 - 1;
                if (hi > 64'd2147483647)
                    hi = 64'd2147483647;
                return VALUE_W'(lo + (longint'($urandom) % (hi - lo + 1)));
            end
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            value <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                convert_value(value);
                void'(values_to_send.pop_front());
            end
            if (!(push && full))
            begin
                if (values_to_send.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    push <= 1'b1;
                    value <= values_to_send[0];
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        dec_char_t due;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (chars_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result digit_char=%0d empty_res=%0b last=%0b",
                             $time, digit_char, empty_res, last);
                end
                else
                begin
                    due = chars_due.pop_front();
                    if ({digit_char, empty_res, last} !== due)
                    begin
                        errors++;
                        $display("%0t: mismatch expected digit_char=%0d empty_res=%0b last=%0b",
                                 $time, due.ch, due.blank, due.fin);
                        $display("%0t:          actual   digit_char=%0d empty_res=%0b last=%0b",
                                 $time, digit_char, empty_res, last);
                    end
                end
            end
            if (hold_go && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                pop <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (values_to_send.size() > 0 || chars_due.size() > 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes, truncation, zero and negatives
        values_to_send.push_back(32'd0);
        values_to_send.push_back(32'd1);
        values_to_send.push_back(32'd9);
        values_to_send.push_back(32'd10);
        values_to_send.push_back(32'd42);
        values_to_send.push_back(32'd7);
        values_to_send.push_back(32'd99999999);
        values_to_send.push_back(32'd10000000);
        values_to_send.push_back(32'd100000000);
        values_to_send.push_back(32'd123456789);
        values_to_send.push_back(32'd1000000000);
        values_to_send.push_back(32'd2147483647);
        values_to_send.push_back(32'd1999999999);
        values_to_send.push_back(32'd10203040);
        values_to_send.push_back(32'd90000009);
        values_to_send.push_back(32'hFFFF_FFFF);
        values_to_send.push_back(32'h8000_0000);
        values_to_send.push_back(32'h5555_5555);
        values_to_send.push_back(32'hAAAA_AAAA);
        wait_drained();

        // receiver holds off while the sender keeps offering
        hold_go = 1'b1;
        repeat (30) values_to_send.push_back(random_value());
        wait_drained();

        // no idling on either side
        calm = 1'b1;
        repeat (40) values_to_send.push_back(random_value());
        wait_drained();
        calm = 1'b0;

        repeat (21) values_to_send.push_back(random_value());
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
hdl/b2da_pkg.sv
hdl/b2da_front.sv
hdl/b2da_queue.sv
hdl/b2da_back.sv
hdl/binary_to_decimal_ascii.sv
hdl/b2da_checker.sv
sim/tb_top.sv
